// File: sv/decision_tree_classifier_top_defines.svh
// ----------------------------------------------------------------------------
// decision tree classifier assertion macros
// shared property forms for the classifier checks
// ----------------------------------------------------------------------------
`ifndef DECISION_TREE_CLASSIFIER_TOP_DEFINES_SVH
`define DECISION_TREE_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication
`define DTC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg
// request codes and fixed field widths of the decision tree classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtc_pkg;

  typedef logic [1:0] action_t;

  localparam action_t ACT_NODE     = 2'd0;
  localparam action_t ACT_FEATURE  = 2'd1;
  localparam action_t ACT_CLASSIFY = 2'd2;

  localparam int NODE_DEPTH  = 1024;
  localparam int NODE_AW     = 10;
  localparam int ATTR_W      = 6;
  localparam int THR_W       = 32;
  localparam int FEAT_W      = 32;
  localparam int OUT_LABEL_W = 8;
  localparam int IN_LABEL_W  = 8;
  localparam int MAX_LABEL_W = 16;
  localparam int FEAT_STORE  = 64;
  localparam int FEAT_CNT_W  = 11;

endpackage

// File: sv/dtc_ram.sv
// ----------------------------------------------------------------------------
// dtc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/dtc_walk.sv
// ----------------------------------------------------------------------------
// dtc_walk
// tree walk sequencer: node read, feature read, compare, step to child
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtc_walk #(
  parameter int TREE_LEVELS  = 10,
  parameter int NUM_FEATURES = 64,
  parameter int LABEL_BITS   = 8,
  parameter int FEAT_AW      = 6
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        go,
  output logic                                        busy,
  input  logic [2+dtc_pkg::ATTR_W+dtc_pkg::THR_W+LABEL_BITS-1:0] node_rdata,
  output logic [dtc_pkg::NODE_AW-1:0]                 node_raddr,
  input  logic [dtc_pkg::FEAT_W-1:0]                  feat_rdata,
  output logic [FEAT_AW-1:0]                          feat_raddr,
  output logic                                        out_valid,
  output logic [dtc_pkg::OUT_LABEL_W-1:0]             out_class_label,
  output logic                                        out_walk_error
);

  localparam int NODE_W = 2 + dtc_pkg::ATTR_W + dtc_pkg::THR_W + LABEL_BITS;
  localparam int LVL_W  = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS + 1) : 1;
  localparam int CH_W   = dtc_pkg::NODE_AW + 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_NODE = 2'd1;
  localparam logic [1:0] ST_FEAT = 2'd2;

  localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(TREE_LEVELS - 1);
  localparam logic [dtc_pkg::FEAT_CNT_W-1:0] NF = dtc_pkg::FEAT_CNT_W'(NUM_FEATURES);
  localparam logic [CH_W-1:0] CHILD_L = CH_W'(1);
  localparam logic [CH_W-1:0] CHILD_R = CH_W'(2);

  logic [1:0]                     state_r, state_nxt;
  logic [dtc_pkg::NODE_AW-1:0]    node_r, node_nxt;
  logic [LVL_W-1:0]               level_r, level_nxt;
  logic [dtc_pkg::THR_W-1:0]      thr_r, thr_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [dtc_pkg::OUT_LABEL_W-1:0] out_label_r, out_label_nxt;
  logic                           out_err_r, out_err_nxt;

  logic                           n_valid;
  logic                           n_leaf;
  logic [dtc_pkg::ATTR_W-1:0]     n_attr;
  logic [dtc_pkg::THR_W-1:0]      n_thr;
  logic [dtc_pkg::MAX_LABEL_W-1:0] n_label16;
  logic                           attr_bad;
  logic                           go_left;
  logic [CH_W-1:0]                child_c;
  logic                           child_out;

  assign n_valid   = node_rdata[NODE_W-1];
  assign n_leaf    = node_rdata[NODE_W-2];
  assign n_attr    = node_rdata[NODE_W-3 -: dtc_pkg::ATTR_W];
  assign n_thr     = node_rdata[LABEL_BITS +: dtc_pkg::THR_W];
  assign n_label16 = dtc_pkg::MAX_LABEL_W'(node_rdata[LABEL_BITS-1:0]);
  assign attr_bad  = {{(dtc_pkg::FEAT_CNT_W - dtc_pkg::ATTR_W){1'b0}}, n_attr} >= NF;

  assign go_left   = $signed(feat_rdata) < $signed(thr_r);
  assign child_c   = {1'b0, node_r, 1'b0} + (go_left ? CHILD_L : CHILD_R);
  assign child_out = child_c[CH_W-1:dtc_pkg::NODE_AW] != 2'b00;

  assign feat_raddr = n_attr[FEAT_AW-1:0];

  always_comb begin
    unique case (state_r)
      ST_FEAT: node_raddr = child_c[dtc_pkg::NODE_AW-1:0];
      ST_NODE: node_raddr = node_r;
      default: node_raddr = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    level_nxt     = level_r;
    thr_nxt       = thr_r;
    out_valid_nxt = 1'b0;
    out_label_nxt = out_label_r;
    out_err_nxt   = out_err_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          node_nxt  = '0;
          level_nxt = '0;
          state_nxt = ST_NODE;
        end
      end
      ST_NODE: begin
        priority if (!n_valid || (!n_leaf && attr_bad)) begin
          out_valid_nxt = 1'b1;
          out_label_nxt = '0;
          out_err_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (n_leaf) begin
          out_valid_nxt = 1'b1;
          out_label_nxt = n_label16[dtc_pkg::OUT_LABEL_W-1:0];
          out_err_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          thr_nxt   = n_thr;
          state_nxt = ST_FEAT;
        end
      end
      ST_FEAT: begin
        if ((level_r == LVL_LAST) || child_out) begin
          out_valid_nxt = 1'b1;
          out_label_nxt = '0;
          out_err_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          node_nxt  = child_c[dtc_pkg::NODE_AW-1:0];
          level_nxt = level_r + LVL_W'(1);
          state_nxt = ST_NODE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    node_r      <= node_nxt;
    level_r     <= level_nxt;
    thr_r       <= thr_nxt;
    out_label_r <= out_label_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign busy            = state_r != ST_IDLE;
  assign out_valid       = out_valid_r;
  assign out_class_label = out_label_r;
  assign out_walk_error  = out_err_r;

endmodule

// File: sv/decision_tree_classifier_top.sv
// ----------------------------------------------------------------------------
// decision_tree_classifier_top
// decision tree inference over an implicit binary tree in a node memory
// ----------------------------------------------------------------------------
// Requests enter on the in_ ports and are taken on a clock edge where start
// is high and busy is low. A node write stores one tree entry and a feature
// write with an index below NUM_FEATURES stores one attribute of the current
// instance; neither gives a result. A classify walks the tree from the root
// and gives one result on out_class_label / out_walk_error, marked by
// out_valid for one cycle. Results cannot be held off by the receiver.
// Each visited split node costs a node memory read and a feature memory read.
// A walk keeps busy high from the request until it stops; one that runs too
// deep or off the table stops after the feature read of its last split.
// The next request may be taken in the result cycle.
// After reset the node memory is swept clear, one entry per cycle, with busy
// high; the feature store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decision_tree_classifier_top_defines.svh"

module decision_tree_classifier_top #(
  parameter int TREE_LEVELS  = 10,
  parameter int NUM_FEATURES = 64,
  parameter int LABEL_BITS   = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_action,
  input  logic [dtc_pkg::NODE_AW-1:0]           in_node_index,
  input  logic                                  in_node_is_leaf,
  input  logic [dtc_pkg::ATTR_W-1:0]            in_node_attribute,
  input  logic signed [dtc_pkg::THR_W-1:0]      in_node_threshold,
  input  logic [dtc_pkg::IN_LABEL_W-1:0]        in_node_label,
  input  logic [dtc_pkg::ATTR_W-1:0]            in_feature_index,
  input  logic signed [dtc_pkg::FEAT_W-1:0]     in_feature_value,
  output logic                                  out_valid,
  output logic [dtc_pkg::OUT_LABEL_W-1:0]       out_class_label,
  output logic                                  out_walk_error
);

  localparam int NODE_W     = 2 + dtc_pkg::ATTR_W + dtc_pkg::THR_W + LABEL_BITS;
  localparam int FEAT_DEPTH = (NUM_FEATURES < dtc_pkg::FEAT_STORE) ?
                              NUM_FEATURES : dtc_pkg::FEAT_STORE;
  localparam int FEAT_AW    = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
  localparam logic [dtc_pkg::FEAT_CNT_W-1:0] NF = dtc_pkg::FEAT_CNT_W'(NUM_FEATURES);

  logic                            clearing_r, clearing_nxt;
  logic [dtc_pkg::NODE_AW-1:0]     clr_r, clr_nxt;

  logic                            accept;
  logic                            walk_go;
  logic                            walk_busy;
  logic                            feat_in_range;
  logic [dtc_pkg::MAX_LABEL_W-1:0] in_label16;

  logic                            node_we;
  logic [dtc_pkg::NODE_AW-1:0]     node_waddr;
  logic [NODE_W-1:0]               node_wdata;
  logic [dtc_pkg::NODE_AW-1:0]     node_raddr;
  logic [NODE_W-1:0]               node_rdata;

  logic                            feat_we;
  logic [FEAT_AW-1:0]              feat_raddr;
  logic [dtc_pkg::FEAT_W-1:0]      feat_rdata;

  assign accept        = start && !busy;
  assign busy          = clearing_r || walk_busy;
  assign walk_go       = accept && (in_action == dtc_pkg::ACT_CLASSIFY);
  assign feat_in_range = {{(dtc_pkg::FEAT_CNT_W - dtc_pkg::ATTR_W){1'b0}}, in_feature_index} < NF;
  assign in_label16    = dtc_pkg::MAX_LABEL_W'(in_node_label);

  // clearing sweep after reset
  always_comb begin
    clearing_nxt = clearing_r;
    clr_nxt      = clr_r;
    if (clearing_r) begin
      clr_nxt = clr_r + dtc_pkg::NODE_AW'(1);
      if (clr_r == {dtc_pkg::NODE_AW{1'b1}}) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_r      <= clr_nxt;
    end
  end

  assign node_we    = clearing_r || (accept && (in_action == dtc_pkg::ACT_NODE));
  assign node_waddr = clearing_r ? clr_r : in_node_index;
  assign node_wdata = clearing_r ? '0 :
                      {1'b1, in_node_is_leaf, in_node_attribute, in_node_threshold,
                       in_label16[LABEL_BITS-1:0]};

  assign feat_we = accept && (in_action == dtc_pkg::ACT_FEATURE) && feat_in_range;

  dtc_ram #(
    .WIDTH (NODE_W),
    .DEPTH (dtc_pkg::NODE_DEPTH)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  dtc_ram #(
    .WIDTH (dtc_pkg::FEAT_W),
    .DEPTH (FEAT_DEPTH)
  ) u_feat_ram (
    .clk   (clk),
    .we    (feat_we),
    .waddr (in_feature_index[FEAT_AW-1:0]),
    .wdata (in_feature_value),
    .raddr (feat_raddr),
    .rdata (feat_rdata)
  );

  dtc_walk #(
    .TREE_LEVELS  (TREE_LEVELS),
    .NUM_FEATURES (NUM_FEATURES),
    .LABEL_BITS   (LABEL_BITS),
    .FEAT_AW      (FEAT_AW)
  ) u_walk (
    .clk             (clk),
    .rst_n           (rst_n),
    .go              (walk_go),
    .busy            (walk_busy),
    .node_rdata      (node_rdata),
    .node_raddr      (node_raddr),
    .feat_rdata      (feat_rdata),
    .feat_raddr      (feat_raddr),
    .out_valid       (out_valid),
    .out_class_label (out_class_label),
    .out_walk_error  (out_walk_error)
  );

  `DTC_ASSERT_NOW(a_no_result_in_clear, clearing_r, !out_valid, "result during clear sweep")
  `DTC_ASSERT_NEXT(a_go_starts_walk, walk_go, walk_busy, "classify did not start walk")
  `DTC_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `DTC_ASSERT_NOW(a_error_label_zero, out_valid && out_walk_error, out_class_label == '0, "error result with nonzero label")

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// decision tree classifier testbench
// Loads node tables and instance features and fires classify requests at the
// classifier. A queue of planned requests, built up front from a directed
// opening and random tree-building and noise episodes, feeds a clocked
// driver with random idle bursts and one or more drain pauses. The driver
// updates a local copy of the node table and feature store on every accepted
// request and walks the tree for each classify. The monitor checks every
// result strobe against the oldest expected verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import dtc_pkg::*;

  localparam int TREE_LEVELS  = 10;
  localparam int NUM_FEATURES = 64;
  localparam int LABEL_BITS   = 8;

  localparam action_t ACT_UNUSED = 2'd3;

  localparam int PRED = 0;
  localparam int PLAN = 1;

  localparam int RANDOM_ITEMS = 750;
  localparam int CALM_ITEMS   = 80;
  localparam int SETTLE       = 2 * TREE_LEVELS + 10;
  localparam int END_LIMIT    = 400000;

  localparam logic signed [31:0] MIN_Q = 32'sh8000_0000;
  localparam logic signed [31:0] MAX_Q = 32'sh7fff_ffff;

  typedef struct packed {
    logic                     valid;
    logic                     leaf;
    logic [ATTR_W-1:0]        attr;
    logic signed [THR_W-1:0]  thr;
    logic [IN_LABEL_W-1:0]    label;
  } tree_node_t;

  typedef struct packed {
    action_t                  action;
    logic [NODE_AW-1:0]       node_index;
    logic                     node_is_leaf;
    logic [ATTR_W-1:0]        node_attribute;
    logic signed [THR_W-1:0]  node_threshold;
    logic [IN_LABEL_W-1:0]    node_label;
    logic [ATTR_W-1:0]        feature_index;
    logic signed [FEAT_W-1:0] feature_value;
  } request_t;

  typedef struct packed {
    logic [OUT_LABEL_W-1:0] label;
    logic                   err;
  } verdict_t;

  typedef struct {
    request_t    req;
    int unsigned gap;
    bit          drain;
  } pending_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic out_valid;
  logic [OUT_LABEL_W-1:0] out_class_label;
  logic out_walk_error;

  request_t cur = '0;

  pending_t pending[$];
  verdict_t expected_verdicts[$];

  tree_node_t              pred_nodes [NODE_DEPTH];
  logic signed [FEAT_W-1:0] pred_feat [FEAT_STORE];
  tree_node_t              plan_nodes [NODE_DEPTH];
  logic signed [FEAT_W-1:0] plan_feat [FEAT_STORE];
  bit                      plan_set   [FEAT_STORE];

  bit          idle_on = 1'b1;
  bit          drain_next = 1'b0;
  int          planned = 0;
  int unsigned idle_left = 0;
  int          mismatches = 0;

  decision_tree_classifier_top #(
    .TREE_LEVELS  (TREE_LEVELS),
    .NUM_FEATURES (NUM_FEATURES),
    .LABEL_BITS   (LABEL_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (cur.action),
    .in_node_index     (cur.node_index),
    .in_node_is_leaf   (cur.node_is_leaf),
    .in_node_attribute (cur.node_attribute),
    .in_node_threshold (cur.node_threshold),
    .in_node_label     (cur.node_label),
    .in_feature_index  (cur.feature_index),
    .in_feature_value  (cur.feature_value),
    .out_valid         (out_valid),
    .out_class_label   (out_class_label),
    .out_walk_error    (out_walk_error)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic tree_node_t node_of(request_t r);
    tree_node_t e;
    e.valid = 1'b1;
    e.leaf  = r.node_is_leaf;
    e.attr  = r.node_attribute;
    e.thr   = r.node_threshold;
    e.label = r.node_label & IN_LABEL_W'((1 << LABEL_BITS) - 1);
    return e;
  endfunction

  // walk from the root; for the plan copy, stop at the first unset feature
  function automatic verdict_t walk_tree(input int m, output int missing);
    verdict_t v;
    tree_node_t e;
    int n;
    logic signed [FEAT_W-1:0] f;
    v = '{label: '0, err: 1'b1};
    missing = -1;
    n = 0;
    for (int lvl = 0; lvl < TREE_LEVELS; lvl++) begin
      if (n >= NODE_DEPTH) return v;
      e = (m == PRED) ? pred_nodes[n] : plan_nodes[n];
      if (!e.valid) return v;
      if (e.leaf) begin
        v.label = OUT_LABEL_W'(e.label);
        v.err   = 1'b0;
        return v;
      end
      if (int'(e.attr) >= NUM_FEATURES) return v;
      if (m == PLAN && !plan_set[e.attr]) begin
        missing = int'(e.attr);
        return v;
      end
      f = (m == PRED) ? pred_feat[e.attr] : plan_feat[e.attr];
      n = ($signed(f) < $signed(e.thr)) ? 2 * n + 1 : 2 * n + 2;
    end
    return v;
  endfunction

  function automatic int level_of(int n);
    int l;
    l = 0;
    while (n > 0) begin
      n = (n - 1) / 2;
      l++;
    end
    return l;
  endfunction

  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(0, 5))
      0: return MIN_Q;
      1: return MAX_Q;
      2: return '0;
      3: return 32'($urandom_range(0, 20'hFFFFF)) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic request_t bare_req(action_t act);
    request_t r;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(request_t)-1:0];
    r.action = act;
    return r;
  endfunction

  function automatic request_t node_req(int idx, bit leaf, int attr,
                                        logic signed [31:0] thr, int label);
    request_t r;
    r = bare_req(ACT_NODE);
    r.node_index     = NODE_AW'(idx);
    r.node_is_leaf   = leaf;
    r.node_attribute = ATTR_W'(attr);
    r.node_threshold = thr;
    r.node_label     = IN_LABEL_W'(label);
    return r;
  endfunction

  function automatic request_t feature_req(int idx, logic signed [31:0] val);
    request_t r;
    r = bare_req(ACT_FEATURE);
    r.feature_index = ATTR_W'(idx);
    r.feature_value = val;
    return r;
  endfunction

  task automatic plan_push(request_t r);
    pending_t p;
    p.req   = r;
    p.gap   = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    p.drain = drain_next || (idle_on && $urandom_range(0, 59) == 0);
    drain_next = 1'b0;
    pending.insert(pending.size(), p);
    case (r.action)
      ACT_NODE: begin
        plan_nodes[r.node_index] = node_of(r);
        planned++;
      end
      ACT_FEATURE: begin
        if (int'(r.feature_index) < NUM_FEATURES) begin
          plan_feat[r.feature_index] = r.feature_value;
          plan_set[r.feature_index]  = 1'b1;
        end
        planned++;
      end
      ACT_CLASSIFY: planned++;
      default: ;
    endcase
  endtask

  // fill in any feature the walk would read before it was ever written
  task automatic plan_classify();
    verdict_t v;
    int miss;
    v = walk_tree(PLAN, miss);
    while (miss >= 0) begin
      plan_push(feature_req(miss, pick_q16()));
      v = walk_tree(PLAN, miss);
    end
    plan_push(bare_req(ACT_CLASSIFY));
  endtask

  task automatic plan_tree(int depth, int budget, int skip_pct);
    int stack[$];
    int attrs[$];
    logic signed [31:0] thrs[$];
    int n;
    int made;
    int a;
    request_t r;
    logic signed [31:0] t;
    logic signed [31:0] val;
    made = 0;
    stack.insert(stack.size(), 0);
    while (stack.size() != 0) begin
      n = stack.pop_back();
      if ($urandom_range(0, 99) < skip_pct) continue;
      r = bare_req(ACT_NODE);
      r.node_index = NODE_AW'(n);
      if (level_of(n) >= depth - 1 || made >= budget || $urandom_range(0, 3) == 0) begin
        r.node_is_leaf = 1'b1;
      end else begin
        r.node_is_leaf = 1'b0;
        a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
        t = pick_q16();
        r.node_attribute = ATTR_W'(a);
        r.node_threshold = t;
        attrs.insert(attrs.size(), a);
        thrs.insert(thrs.size(), t);
        if (2 * n + 2 < NODE_DEPTH) stack.insert(stack.size(), 2 * n + 2);
        if (2 * n + 1 < NODE_DEPTH) stack.insert(stack.size(), 2 * n + 1);
      end
      plan_push(r);
      made++;
    end
    repeat ($urandom_range(1, 4)) begin
      if (attrs.size() != 0) begin
        repeat ($urandom_range(0, 3)) begin
          t = thrs[$urandom_range(0, thrs.size() - 1)];
          case ($urandom_range(0, 2))
            0: val = pick_q16();
            1: val = t;
            default: val = t - 1;
          endcase
          plan_push(feature_req(attrs[$urandom_range(0, attrs.size() - 1)], val));
        end
      end
      plan_classify();
    end
  endtask

  task automatic plan_noise();
    case ($urandom_range(0, 3))
      0: plan_push(bare_req(ACT_NODE));
      1: plan_push(feature_req($urandom_range(0, 63), pick_q16()));
      2: plan_classify();
      default: plan_push(bare_req(ACT_UNUSED));
    endcase
  endtask

  function automatic void tally(string what, logic [31:0] want, logic [31:0] got);
    if (mismatches < 10)
      $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $time);
    mismatches++;
  endfunction

  always @(posedge clk) begin : driver
    verdict_t v;
    int miss;
    if (!rst_n) begin
      start <= 1'b0;
      idle_left <= 0;
    end else begin
      if (start && !busy) begin
        case (cur.action)
          ACT_NODE: pred_nodes[cur.node_index] = node_of(cur);
          ACT_FEATURE: begin
            if (int'(cur.feature_index) < NUM_FEATURES)
              pred_feat[cur.feature_index] = cur.feature_value;
          end
          ACT_CLASSIFY: begin
            v = walk_tree(PRED, miss);
            expected_verdicts.insert(expected_verdicts.size(), v);
          end
          default: ;
        endcase
      end
      if (!start || !busy) begin
        if (idle_left != 0) begin
          start <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (pending.size() == 0
                     || (pending[0].drain && expected_verdicts.size() != 0)) begin
          start <= 1'b0;
        end else begin
          cur <= pending[0].req;
          idle_left <= (pending.size() > 1) ? pending[1].gap : 0;
          pending.pop_front();
          start <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    verdict_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (expected_verdicts.size() == 0) begin
        tally("result with no classify pending", '0,
              32'({out_walk_error, out_class_label}));
      end else begin
        want = expected_verdicts.pop_front();
        if (out_class_label !== want.label)
          tally("class_label", 32'(want.label), 32'(out_class_label));
        if (out_walk_error !== want.err)
          tally("walk_error", 32'(want.err), 32'(out_walk_error));
      end
    end
  end

  initial begin
    int n;
    int guard;
    for (int i = 0; i < NODE_DEPTH; i++) begin
      pred_nodes[i] = '0;
      plan_nodes[i] = '0;
    end
    for (int i = 0; i < FEAT_STORE; i++) begin
      pred_feat[i] = '0;
      plan_feat[i] = '0;
      plan_set[i]  = 1'b0;
    end

    // empty table, unused action, root leaf
    plan_classify();
    plan_push('1);
    plan_push(node_req(0, 1'b1, 0, '0, 8'hFF));
    plan_classify();
    // feature equal to threshold goes right, at both extremes
    plan_push(node_req(0, 1'b0, 63, MIN_Q, 0));
    plan_push(feature_req(63, MIN_Q));
    plan_push(node_req(2, 1'b1, 0, '0, 8'h00));
    plan_classify();
    plan_push(node_req(0, 1'b0, 63, MAX_Q, 0));
    plan_push(feature_req(63, MAX_Q));
    plan_classify();
    // left child not yet written, then written
    plan_push(feature_req(63, MAX_Q - 1));
    plan_classify();
    plan_push(node_req(1, 1'b1, 0, '0, 8'hA5));
    plan_classify();
    // left spine of splits down to the last level runs too deep
    for (n = 1; n < NODE_DEPTH / 2; n = 2 * n + 1)
      plan_push(node_req(n, 1'b0, 63, MAX_Q, 0));
    plan_push(node_req(NODE_DEPTH - 1, 1'b1, 0, '0, 8'h5A));
    plan_classify();

    drain_next = 1'b1;
    n = planned + RANDOM_ITEMS;
    while (planned < n) begin
      if (planned >= n - CALM_ITEMS) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6:
          plan_tree(($urandom_range(0, 4) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 5),
                    $urandom_range(3, 24), 0);
        7: plan_tree($urandom_range(2, 11), $urandom_range(3, 24), 25);
        default: repeat ($urandom_range(1, 4)) plan_noise();
      endcase
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    guard = 0;
    while ((pending.size() != 0 || start || expected_verdicts.size() != 0)
           && guard < END_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE) @(negedge clk);

    if (expected_verdicts.size() != 0)
      $display("classify results never seen: %0d", expected_verdicts.size());
    if (mismatches == 0 && expected_verdicts.size() == 0 && pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
